>>> hdl/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg: shared types and constants of the prefix routing table
// Key, digit and address geometry, command and result beats, slot layout.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int KEY_BITS     = 64;
    localparam int DIGIT_BITS   = 4;
    localparam int ADDRESS_BITS = 32;

    localparam int NROWS     = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int NCOLS     = 1 << DIGIT_BITS;
    localparam int NSLOTS    = NROWS * NCOLS;
    localparam int PAD_BITS  = NROWS * DIGIT_BITS;
    localparam int PAD_LOW   = PAD_BITS - KEY_BITS;
    localparam int ROW_BITS  = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int RIU_BITS  = $clog2(NROWS + 1);
    localparam int SLOT_BITS = ROW_BITS + DIGIT_BITS;
    localparam int ADDR_W    = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;

    localparam logic [1:0] KIND_MERGE  = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_FAIL   = 2'd2;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_OWNER = 2'd1;
    localparam logic [1:0] STATUS_NONE  = 2'd2;
    localparam logic [1:0] STATUS_KEPT  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] node_key;
        logic [31:0] node_address;
        logic [31:0] proximity;
    } prt_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] hop_key;
        logic [31:0] hop_address;
        logic [3:0]  table_row;
        logic [3:0]  table_column;
    } prt_result_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [ADDR_W-1:0]   address;
        logic [31:0]         proximity;
    } prt_slot_t;

    typedef struct packed {
        logic [ROW_BITS-1:0]   row;
        logic [DIGIT_BITS-1:0] col;
        logic                  own_equal;
    } prt_index_t;

    function automatic logic [RIU_BITS-1:0] row_to_riu(input logic [ROW_BITS-1:0] row);
        logic [RIU_BITS+ROW_BITS-1:0] wide;
        wide = {{RIU_BITS{1'b0}}, row};
        return wide[RIU_BITS-1:0];
    endfunction

    function automatic logic [3:0] row_to_field(input logic [ROW_BITS-1:0] row);
        logic [ROW_BITS+3:0] wide;
        wide = {4'b0000, row};
        return wide[3:0];
    endfunction

    function automatic logic [3:0] col_to_field(input logic [DIGIT_BITS-1:0] col);
        logic [DIGIT_BITS+3:0] wide;
        wide = {4'b0000, col};
        return wide[3:0];
    endfunction

    function automatic logic [63:0] key_to_field(input logic [KEY_BITS-1:0] key);
        logic [KEY_BITS+63:0] wide;
        wide = {64'd0, key};
        return wide[63:0];
    endfunction

    function automatic logic [31:0] addr_to_field(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W+31:0] wide;
        wide = {32'd0, addr};
        return wide[31:0];
    endfunction

endpackage

>>> hdl/prefix_routing_table.sv
// ----------------------------------------------------------------------------
// prefix_routing_table: prefix routing table of an overlay node
// Merge, lookup and fail commands on a row-by-digit table of next hops.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; exactly one
// result beat follows, shown on result for the single cycle in which done is
// high, and it cannot be held off. Merge and lookup compute the slot from
// the key, read the slot store, then compare, write back and register the
// result. A fail command walks the used rows slot by slot through the
// store's read port, one slot a cycle, and stops early at the first
// matching slot. The owner key is written through cfg_write and cfg_data;
// the user must write it only while the block is idle, which the block
// itself does not enforce. Rewriting it keeps the table contents. After
// reset the table is empty and usable at once.
// ----------------------------------------------------------------------------
module prefix_routing_table
    import prt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [63:0] cfg_data,
    input  logic        start,
    input  prt_cmd_t    cmd,
    output logic        busy,
    output logic        done,
    output prt_result_t result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam logic [1:0] ST_SCAN = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [63:0]           owner_key_reg;
    logic [RIU_BITS-1:0]   rows_in_use_reg, rows_in_use_next;
    logic                  slot_valid_reg [NSLOTS];

    // Command held for the duration of its work.
    logic [1:0]            kind_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [31:0]           prox_reg;

    // Fail scan: next slot to read, and the slot whose data is now back.
    logic [ROW_BITS-1:0]   scan_row_reg, scan_row_next;
    logic [DIGIT_BITS-1:0] scan_col_reg, scan_col_next;
    logic                  scan_issue_reg, scan_issue_next;
    logic                  pend_reg, pend_next;

    logic [SLOT_BITS-1:0]  rd_slot;
    logic [SLOT_BITS-1:0]  rd_slot_reg;
    logic                  rd_valid_reg;
    prt_slot_t             rd_data;

    logic                  wr_en;
    prt_slot_t             wr_data;
    logic                  set_valid;
    logic                  clear_valid;

    logic                  done_reg, done_next;
    prt_result_t           result_reg, result_next;

    prt_index_t            index;
    logic                  accept;
    logic [SLOT_BITS-1:0]  index_slot;

    assign accept     = start && (state_reg == ST_IDLE);
    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign result     = result_reg;
    assign index_slot = {index.row, index.col};

    prt_slot_index u_index
    (
        .clk       (clk),
        .load      (accept),
        .owner_key (owner_key_reg[KEY_BITS-1:0]),
        .node_key  (cmd.node_key[KEY_BITS-1:0]),
        .index     (index)
    );

    prt_slot_ram u_ram
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_slot (index_slot),
        .wr_data (wr_data),
        .rd_slot (rd_slot),
        .rd_data (rd_data)
    );

    assign rd_slot = (state_reg == ST_SCAN) ? {scan_row_reg, scan_col_reg} : index_slot;

    assign wr_data.key       = key_reg;
    assign wr_data.address   = addr_reg;
    assign wr_data.proximity = prox_reg;

    always_comb
    begin
        state_next       = state_reg;
        rows_in_use_next = rows_in_use_reg;
        scan_row_next    = scan_row_reg;
        scan_col_next    = scan_col_reg;
        scan_issue_next  = scan_issue_reg;
        pend_next        = pend_reg;
        wr_en            = 1'b0;
        set_valid        = 1'b0;
        clear_valid      = 1'b0;
        done_next        = 1'b0;
        result_next      = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    scan_row_next   = '0;
                    scan_col_next   = '0;
                    scan_issue_next = 1'b1;
                    pend_next       = 1'b0;
                    state_next      = (cmd.kind == KIND_FAIL) ? ST_SCAN : ST_READ;
                end
            end

            ST_READ:
            begin
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                state_next               = ST_IDLE;
                done_next                = 1'b1;
                result_next.status       = STATUS_NONE;
                result_next.hop_key      = '0;
                result_next.hop_address  = '0;
                result_next.table_row    = '0;
                result_next.table_column = '0;
                if (kind_reg == KIND_MERGE || kind_reg == KIND_LOOKUP)
                begin
                    if (index.own_equal)
                    begin
                        result_next.status = STATUS_OWNER;
                    end
                    else
                    begin
                        result_next.table_row    = row_to_field(index.row);
                        result_next.table_column = col_to_field(index.col);
                        if (kind_reg == KIND_MERGE)
                        begin
                            if (rows_in_use_reg < row_to_riu(index.row) + 1'b1)
                            begin
                                rows_in_use_next = row_to_riu(index.row) + 1'b1;
                            end
                            if (!rd_valid_reg || prox_reg < rd_data.proximity)
                            begin
                                wr_en              = 1'b1;
                                set_valid          = 1'b1;
                                result_next.status = STATUS_DONE;
                            end
                            else
                            begin
                                result_next.status = STATUS_KEPT;
                            end
                        end
                        else if (row_to_riu(index.row) < rows_in_use_reg && rd_valid_reg)
                        begin
                            result_next.status      = STATUS_DONE;
                            result_next.hop_key     = key_to_field(rd_data.key);
                            result_next.hop_address = addr_to_field(rd_data.address);
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (pend_reg && rd_valid_reg && rd_data.address == addr_reg)
                begin
                    clear_valid              = 1'b1;
                    state_next               = ST_IDLE;
                    done_next                = 1'b1;
                    result_next.status       = STATUS_DONE;
                    result_next.hop_key      = '0;
                    result_next.hop_address  = '0;
                    result_next.table_row    =
                        row_to_field(rd_slot_reg[SLOT_BITS-1 -: ROW_BITS]);
                    result_next.table_column = col_to_field(rd_slot_reg[DIGIT_BITS-1:0]);
                end
                else if (!scan_issue_reg && !pend_reg)
                begin
                    state_next               = ST_IDLE;
                    done_next                = 1'b1;
                    result_next.status       = STATUS_NONE;
                    result_next.hop_key      = '0;
                    result_next.hop_address  = '0;
                    result_next.table_row    = '0;
                    result_next.table_column = '0;
                end
                else
                begin
                    pend_next = scan_issue_reg;
                    if (scan_issue_reg)
                    begin
                        scan_col_next = scan_col_reg + 1'b1;
                        if (scan_col_reg == '1)
                        begin
                            scan_row_next = scan_row_reg + 1'b1;
                            if (row_to_riu(scan_row_reg) + 1'b1 >= rows_in_use_reg)
                            begin
                                scan_issue_next = 1'b0;
                            end
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            owner_key_reg   <= '0;
            rows_in_use_reg <= RIU_BITS'(1);
            scan_issue_reg  <= 1'b0;
            pend_reg        <= 1'b0;
            done_reg        <= 1'b0;
            for (int i = 0; i < NSLOTS; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            rows_in_use_reg <= rows_in_use_next;
            scan_issue_reg  <= scan_issue_next;
            pend_reg        <= pend_next;
            done_reg        <= done_next;
            if (cfg_write)
            begin
                owner_key_reg <= cfg_data;
            end
            if (set_valid)
            begin
                slot_valid_reg[index_slot] <= 1'b1;
            end
            if (clear_valid)
            begin
                slot_valid_reg[rd_slot_reg] <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= cmd.kind;
            key_reg  <= cmd.node_key[KEY_BITS-1:0];
            addr_reg <= cmd.node_address[ADDR_W-1:0];
            prox_reg <= cmd.proximity;
        end
        scan_row_reg <= scan_row_next;
        scan_col_reg <= scan_col_next;
        rd_slot_reg  <= rd_slot;
        rd_valid_reg <= slot_valid_reg[rd_slot];
        result_reg   <= result_next;
    end

    // A result beat only appears once the block has returned to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_rows_range: assert property (@(posedge clk) disable iff (!rst_n)
        rows_in_use_reg != '0 && rows_in_use_reg <= NROWS)
        else $error("rows in use out of range");

    a_owner_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STATUS_OWNER) |->
        (result.table_row == '0 && result.table_column == '0 && result.hop_key == '0))
        else $error("owner key result carries slot data");

endmodule

>>> hdl/prt_slot_ram.sv
// ----------------------------------------------------------------------------
// prt_slot_ram: slot store of the routing table
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module prt_slot_ram
    import prt_pkg::*;
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [SLOT_BITS-1:0] wr_slot,
    input  prt_slot_t            wr_data,
    input  logic [SLOT_BITS-1:0] rd_slot,
    output prt_slot_t            rd_data
);

    prt_slot_t mem [NSLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_slot];
    end

endmodule

>>> hdl/prt_slot_index.sv
// ----------------------------------------------------------------------------
// prt_slot_index: row and column of a key against the owner key
// Finds the first differing digit and registers the slot it selects.
// ----------------------------------------------------------------------------
module prt_slot_index
    import prt_pkg::*;
(
    input  logic                clk,
    input  logic                load,
    input  logic [KEY_BITS-1:0] owner_key,
    input  logic [KEY_BITS-1:0] node_key,
    output prt_index_t          index
);

    logic [PAD_BITS-1:0]   key_pad;
    logic [PAD_BITS-1:0]   diff_pad;
    logic [ROW_BITS-1:0]   row;
    logic [DIGIT_BITS-1:0] col;

    // The shorter last digit, if any, is padded with zeros at its low end.
    always_comb
    begin
        key_pad  = PAD_BITS'(node_key) << PAD_LOW;
        diff_pad = PAD_BITS'(owner_key ^ node_key) << PAD_LOW;
        row      = '0;
        col      = key_pad[PAD_BITS-1 -: DIGIT_BITS];
        for (int i = NROWS - 1; i >= 0; i--)
        begin
            if (|diff_pad[PAD_BITS-1-i*DIGIT_BITS -: DIGIT_BITS])
            begin
                row = ROW_BITS'(i);
                col = key_pad[PAD_BITS-1-i*DIGIT_BITS -: DIGIT_BITS];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            index.row       <= row;
            index.col       <= col;
            index.own_equal <= (diff_pad == '0);
        end
    end

endmodule

>>> tb/prt_route_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prt_route_checker: predicting checker for the prefix routing table
// Watches the owner key writes, the command and the result channel, keeps
// its own copy of the table and compares every result beat in order.
// ----------------------------------------------------------------------------
module prt_route_checker
    import prt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [63:0] cfg_data,
    input  logic        start,
    input  logic        busy,
    input  prt_cmd_t    cmd,
    input  logic        done,
    input  prt_result_t result,
    output int          mismatches,
    output int          outstanding
);

    logic [KEY_BITS-1:0] owner;
    bit                  slot_full [NSLOTS];
    logic [KEY_BITS-1:0] slot_key  [NSLOTS];
    logic [ADDR_W-1:0]   slot_addr [NSLOTS];
    logic [31:0]         slot_prox [NSLOTS];
    int                  rows_used;
    prt_result_t         expected_hops [$];

    // Leading bits that two keys have in common.
    function automatic int shared_bits(input logic [KEY_BITS-1:0] a,
                                       input logic [KEY_BITS-1:0] b);
        int n;
        n = 0;
        while (n < KEY_BITS && a[KEY_BITS-1-n] == b[KEY_BITS-1-n])
            n++;
        return n;
    endfunction

    // Digit of a key at a row; a short last digit is padded at its low end.
    function automatic int digit_at(input logic [KEY_BITS-1:0] key, input int row);
        int left;
        int take;
        logic [DIGIT_BITS-1:0] d;
        left = KEY_BITS - row * DIGIT_BITS;
        take = (left < DIGIT_BITS) ? left : DIGIT_BITS;
        d = '0;
        for (int i = 0; i < take; i++)
            d[DIGIT_BITS-1-i] = key[left-1-i];
        return int'(d);
    endfunction

    task automatic route_command(input prt_cmd_t c, output prt_result_t r);
        logic [KEY_BITS-1:0] key;
        logic [ADDR_W-1:0]   addr;
        int row;
        int col;
        int idx;
        bit found;
        key = c.node_key[KEY_BITS-1:0];
        addr = c.node_address[ADDR_W-1:0];
        r = '0;
        r.status = STATUS_NONE;
        if (c.kind == KIND_MERGE || c.kind == KIND_LOOKUP)
        begin
            if (key == owner)
            begin
                r.status = STATUS_OWNER;
            end
            else
            begin
                row = shared_bits(owner, key) / DIGIT_BITS;
                col = digit_at(key, row);
                idx = row * NCOLS + col;
                r.table_row = row[3:0];
                r.table_column = col[3:0];
                if (c.kind == KIND_MERGE)
                begin
                    if (rows_used < row + 1)
                        rows_used = row + 1;
                    if (!slot_full[idx] || c.proximity < slot_prox[idx])
                    begin
                        slot_full[idx] = 1'b1;
                        slot_key[idx] = key;
                        slot_addr[idx] = addr;
                        slot_prox[idx] = c.proximity;
                        r.status = STATUS_DONE;
                    end
                    else
                    begin
                        r.status = STATUS_KEPT;
                    end
                end
                else if (row < rows_used && slot_full[idx])
                begin
                    r.status = STATUS_DONE;
                    r.hop_key[KEY_BITS-1:0] = slot_key[idx];
                    r.hop_address[ADDR_W-1:0] = slot_addr[idx];
                end
            end
        end
        else if (c.kind == KIND_FAIL)
        begin
            found = 1'b0;
            for (int s = 0; s < rows_used * NCOLS && !found; s++)
            begin
                if (slot_full[s] && slot_addr[s] == addr)
                begin
                    slot_full[s] = 1'b0;
                    r.status = STATUS_DONE;
                    r.table_row = 4'(s / NCOLS);
                    r.table_column = 4'(s % NCOLS);
                    found = 1'b1;
                end
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        prt_result_t want;
        if (!rst_n)
        begin
            owner = '0;
            rows_used = 1;
            for (int s = 0; s < NSLOTS; s++)
                slot_full[s] = 1'b0;
            expected_hops.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_hops.size() == 0)
                begin
                    $error("result beat with no command waiting for it");
                    mismatches++;
                end
                else
                begin
                    want = expected_hops.pop_front();
                    compare_field("status", 64'(want.status), 64'(result.status));
                    compare_field("hop_key", want.hop_key, result.hop_key);
                    compare_field("hop_address", 64'(want.hop_address),
                                  64'(result.hop_address));
                    compare_field("table_row", 64'(want.table_row),
                                  64'(result.table_row));
                    compare_field("table_column", 64'(want.table_column),
                                  64'(result.table_column));
                end
            end
            if (cfg_write)
                owner = cfg_data[KEY_BITS-1:0];
            if (start && !busy)
            begin
                route_command(cmd, want);
                expected_hops = {expected_hops, want};
            end
            outstanding = expected_hops.size();
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for the prefix routing table
// Directed and random merge, lookup and fail beats under several owner keys
// and sender idling patterns; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import prt_pkg::*;

    // The kind field is two bits wide, so the unused code must be exercised
    // too: it is a no-op that still answers with a single result beat.
    localparam logic [1:0] KIND_NONE = 2'd3;

    // Longest fail scan plus a small margin; used when draining the block.
    localparam int DRAIN_CYCLES = 16 * NROWS + 8;
    localparam int PHASE_ITEMS  = 125;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_write = 1'b0;
    logic [63:0] cfg_data  = '0;
    logic        start     = 1'b0;
    prt_cmd_t    cmd       = '0;
    logic        busy;
    logic        done;
    prt_result_t result;

    int mismatches;
    int outstanding;

    // Percentage of cycles in which the sender holds back a beat.
    int          sender_idle_pct;
    logic [63:0] owner_now;
    logic [31:0] address_pool [16];
    logic [63:0] merged_keys [$];

    prefix_routing_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result)
    );

    prt_route_checker u_route_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Safety net: even the slowest legal run, with every beat a full fail
    // scan and long sender gaps, finishes well inside this time.
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // A key that shares exactly p leading bits with the owner key: the bit
    // after the shared prefix is flipped and the rest is random. This is
    // what steers beats into the deeper rows of the table.
    function automatic logic [63:0] key_sharing(input logic [63:0] own, input int p);
        logic [63:0] k;
        k = {$urandom, $urandom};
        for (int i = 0; i < 64; i++)
        begin
            if (i < p)
                k[63-i] = own[63-i];
            else if (i == p)
                k[63-i] = ~own[63-i];
        end
        return k;
    endfunction

    // Presents one command beat and returns at the falling edge after it has
    // been taken. Start is left high so that a following beat can come
    // straight away; whoever stops sending must lower it. While the sender
    // idles the command bus carries random noise, which must be ignored.
    task automatic issue(input prt_cmd_t c);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            cmd <= {2'($urandom), $urandom, $urandom, $urandom, $urandom};
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send(input logic [1:0] kind, input logic [63:0] key,
                        input logic [31:0] addr, input logic [31:0] prox);
        prt_cmd_t c;
        c.kind = kind;
        c.node_key = key;
        c.node_address = addr;
        c.proximity = prox;
        issue(c);
    endtask

    // Stops sending and waits until every expected result beat has come,
    // then lets the longest possible scan time pass so the block is idle.
    task automatic drain();
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_owner(input logic [63:0] value);
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        cfg_data <= {$urandom, $urandom};
        @(negedge clk);
        owner_now = value;
    endtask

    // One random beat. Merges use keys with a chosen shared prefix, often a
    // short one so that row zero sees many collisions and proximity fights.
    // Lookups reuse recently merged keys half of the time so that they hit.
    // Addresses come mostly from a small pool so that fail beats match.
    task automatic random_beat(output prt_cmd_t c);
        int roll;
        int p;
        roll = $urandom_range(99);
        c.kind = KIND_MERGE;
        c.node_key = {$urandom, $urandom};
        c.node_address = $urandom;
        c.proximity = $urandom;
        if (roll < 40)
        begin
            p = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(63);
            c.node_key = key_sharing(owner_now, p);
            if ($urandom_range(4) != 0)
                c.node_address = address_pool[$urandom_range(15)];
            roll = $urandom_range(99);
            if (roll < 50)
                c.proximity = $urandom_range(15);
            else if (roll < 60)
                c.proximity = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            merged_keys = {merged_keys, c.node_key};
            if (merged_keys.size() > 32)
                void'(merged_keys.pop_front());
        end
        else if (roll < 72)
        begin
            c.kind = KIND_LOOKUP;
            if (merged_keys.size() != 0 && $urandom_range(1) == 1)
                c.node_key = merged_keys[$urandom_range(merged_keys.size() - 1)];
            else
                c.node_key = key_sharing(owner_now, $urandom_range(63));
        end
        else if (roll < 84)
        begin
            c.kind = KIND_FAIL;
            if ($urandom_range(3) != 0)
                c.node_address = address_pool[$urandom_range(15)];
        end
        else if (roll < 88)
        begin
            c.kind = KIND_NONE;
        end
        else
        begin
            c.kind = $urandom_range(1) ? KIND_MERGE : KIND_LOOKUP;
            c.node_key = owner_now;
        end
    endtask

    initial
    begin : stimulus
        prt_cmd_t    c;
        logic [63:0] own;
        logic [63:0] deep_key;
        logic [63:0] last_key;

        address_pool[0] = 32'h0;
        address_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 16; i++)
            address_pool[i] = $urandom;
        sender_idle_pct = 12;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, under a random owner key.
        write_owner({$urandom, $urandom});
        own = owner_now;
        deep_key = key_sharing(own, 40);
        last_key = key_sharing(own, 63);

        // Row ten lies beyond the rows in use straight after reset.
        send(KIND_LOOKUP, deep_key, $urandom, $urandom);
        // The owner's own key is refused by both merge and lookup.
        send(KIND_MERGE, own, 32'h1234_5678, 32'd1);
        send(KIND_LOOKUP, own, $urandom, $urandom);
        // Row zero: empty slot, first store, equal, lower and higher proximity.
        send(KIND_LOOKUP, ~own, $urandom, $urandom);
        send(KIND_MERGE, ~own, 32'h0, 32'hFFFF_FFFF);
        send(KIND_MERGE, ~own, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(KIND_MERGE, ~own, address_pool[5], 32'd7);
        send(KIND_MERGE, ~own, address_pool[6], 32'd8);
        send(KIND_LOOKUP, ~own, $urandom, $urandom);
        // The very last row, reached by a key that differs only in its lsb.
        send(KIND_MERGE, last_key, address_pool[2], 32'd0);
        send(KIND_LOOKUP, last_key, $urandom, $urandom);
        send(KIND_MERGE, 64'h0, address_pool[3], $urandom);
        send(KIND_MERGE, 64'hFFFF_FFFF_FFFF_FFFF, address_pool[4], $urandom);
        // Fail clears the deep slot; a second fail of the same node misses.
        send(KIND_FAIL, {$urandom, $urandom}, address_pool[2], $urandom);
        send(KIND_LOOKUP, last_key, $urandom, $urandom);
        send(KIND_FAIL, {$urandom, $urandom}, address_pool[2], $urandom);
        send(KIND_FAIL, {$urandom, $urandom}, 32'hFFFF_FFFF, $urandom);
        send(KIND_NONE, {$urandom, $urandom}, $urandom, $urandom);
        send(KIND_MERGE, deep_key, address_pool[7], $urandom);
        send(KIND_LOOKUP, deep_key, $urandom, $urandom);
        send(KIND_FAIL, {$urandom, $urandom}, address_pool[5], $urandom);
        drain();

        // Random part: four owner keys, the table carried across each
        // rewrite. The sender idles lightly, then heavily, then not at all.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: sender_idle_pct = 12;
                1: sender_idle_pct = 77;
                default: sender_idle_pct = 0;
            endcase
            case (phase)
                0: write_owner(owner_now);
                1: write_owner(64'hFFFF_FFFF_FFFF_FFFF);
                2: write_owner(64'h0);
                default: write_owner({$urandom, $urandom});
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                random_beat(c);
                issue(c);
            end
            drain();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
hdl/prt_pkg.sv
hdl/prt_slot_ram.sv
hdl/prt_slot_index.sv
hdl/prefix_routing_table.sv
tb/prt_route_checker.sv
tb/tb.sv
